### hdl/itsr_pkg.sv
// Shared types and constants for the indexed-to-swizzled RGB5A1 texel unit.
`timescale 1ns / 1ps

package itsr_pkg;

    localparam int CFG_W        = 10;
    localparam int TEXEL_W      = 16;
    localparam int ADDR_W       = 19;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd240;

    // Operation codes of an input item
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] palette_slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pixel_code;
    } in_item_t;

    typedef struct packed {
        logic [TEXEL_W-1:0] texel;
        logic [ADDR_W-1:0]  texel_address;
        logic               image_done;
    } out_item_t;

    // Classified work item handed from front to back
    typedef struct packed {
        logic              operation;
        logic [7:0]        index;      // palette slot or pixel code
        logic [23:0]       rgb;        // {red, green, blue}
        logic [ADDR_W-1:0] address;
        logic              done;
    } work_t;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### hdl/itsr_front.sv
// Front end: item intake, raster counters, swizzled address generation.
`timescale 1ns / 1ps

module itsr_front #(
    parameter int MAX_DIM_LOG2 = 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [itsr_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  itsr_pkg::in_item_t            s_item,
    input  itsr_pkg::queue_status_t       q_status,
    output logic                          push,
    output itsr_pkg::work_t               push_entry
);

    localparam int DW        = MAX_DIM_LOG2 + 1;
    localparam int DIM_LIMIT = 1 << MAX_DIM_LOG2;
    localparam int LW        = $clog2(MAX_DIM_LOG2 + 5);

    logic [itsr_pkg::CFG_W-1:0] width_reg, width_next;
    logic [itsr_pkg::CFG_W-1:0] height_reg, height_next;
    logic [MAX_DIM_LOG2-1:0]    col_reg, col_next;
    logic [MAX_DIM_LOG2-1:0]    row_reg, row_next;

    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [LW-1:0] tw_log2;
    logic          col_last;
    logic          row_last;
    logic [31:0]   addr_full;
    logic          accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept;

    // Effective dimensions: zero acts as one, oversize clamps to the limit
    always_comb begin
        if (width_reg == '0) begin
            w_eff = DW'(1);
        end else if (32'(width_reg) > DIM_LIMIT) begin
            w_eff = DW'(DIM_LIMIT);
        end else begin
            w_eff = DW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = DW'(1);
        end else if (32'(height_reg) > DIM_LIMIT) begin
            h_eff = DW'(DIM_LIMIT);
        end else begin
            h_eff = DW'(height_reg);
        end
    end

    // Texture width: smallest power of two >= width, at least 8
    always_comb begin
        tw_log2 = LW'(MAX_DIM_LOG2);
        for (int k = MAX_DIM_LOG2; k >= 3; k--) begin
            if (32'(w_eff) <= (32'd1 << k)) begin
                tw_log2 = LW'(k);
            end
        end
    end

    assign col_last = (32'(col_reg) + 32'd1) >= 32'(w_eff);
    assign row_last = (32'(row_reg) + 32'd1) >= 32'(h_eff);

    // 16-byte x 8-row blocks; texel is 2 bytes so 8 texels per block row
    assign addr_full = ((32'(row_reg >> 3)) << (32'(tw_log2) + 32'd4))
                     | ((32'(col_reg >> 3)) << 7)
                     | ((32'(row_reg[2:0])) << 4)
                     | ((32'(col_reg[2:0])) << 1);

    always_comb begin
        push_entry.operation = s_item.operation;
        push_entry.index     = (s_item.operation == itsr_pkg::OP_PIXEL) ?
                               s_item.pixel_code : s_item.palette_slot;
        push_entry.rgb       = {s_item.red, s_item.green, s_item.blue};
        push_entry.address   = addr_full[itsr_pkg::ADDR_W-1:0];
        push_entry.done      = col_last && row_last;
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                itsr_pkg::CFG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                itsr_pkg::CFG_IMAGE_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
            col_next = '0;
            row_next = '0;
        end else if (accept && s_item.operation == itsr_pkg::OP_PIXEL) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= itsr_pkg::WIDTH_RESET;
            height_reg <= itsr_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

### hdl/itsr_queue.sv
// Short FIFO of classified work items between front and back.
`timescale 1ns / 1ps

module itsr_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  itsr_pkg::work_t          push_entry,
    input  logic                     pop,
    output itsr_pkg::work_t          head,
    output itsr_pkg::queue_status_t  status
);

    localparam int PW = $clog2(itsr_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(itsr_pkg::QUEUE_DEPTH + 1);

    itsr_pkg::work_t slots [itsr_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == CW'(itsr_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slots[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(itsr_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        PW'(wr_ptr_reg - rd_ptr_reg) == count_reg[PW-1:0])
        else $error("queue pointers disagree with count");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow queue");

endmodule

### hdl/itsr_back.sv
// Back end: palette memory, texel packing and output register.
`timescale 1ns / 1ps

module itsr_back #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  itsr_pkg::work_t          head,
    input  itsr_pkg::queue_status_t  q_status,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output itsr_pkg::out_item_t      m_item
);

    localparam int IW = $clog2(PALETTE_ENTRIES);

    logic [23:0] palette_mem [PALETTE_ENTRIES];

    logic                        rd_valid_reg, rd_valid_next;
    logic [23:0]                 rd_rgb_reg;
    logic                        rd_black_reg;
    logic [itsr_pkg::ADDR_W-1:0] rd_addr_reg;
    logic                        rd_done_reg;
    logic                        out_valid_reg, out_valid_next;
    itsr_pkg::out_item_t         out_item_reg;

    logic out_free;
    logic rd_adv;
    logic head_pixel;
    logic head_in_range;

    function automatic logic [itsr_pkg::TEXEL_W-1:0] pack_texel(input logic [23:0] rgb);
        logic [itsr_pkg::TEXEL_W-1:0] t;
        if (rgb == '0) begin
            t = '0;
        end else begin
            t = {1'b1, rgb[7:3], rgb[15:11], rgb[23:19]};
        end
        return t;
    endfunction

    assign out_free      = !out_valid_reg || m_ready;
    assign rd_adv        = rd_valid_reg && out_free;
    assign pop           = !q_status.empty && (!rd_valid_reg || out_free);
    assign head_pixel    = (head.operation == itsr_pkg::OP_PIXEL);
    assign head_in_range = {1'b0, head.index} < 9'(PALETTE_ENTRIES);

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (pop && head_pixel) begin
            rd_valid_next = 1'b1;
        end else if (rd_adv) begin
            rd_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (rd_adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (pop && !head_pixel && head_in_range) begin
            palette_mem[head.index[IW-1:0]] <= head.rgb;
        end
        if (pop && head_pixel) begin
            rd_rgb_reg <= palette_mem[head.index[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_pixel) begin
            rd_black_reg <= !head_in_range;
            rd_addr_reg  <= head.address;
            rd_done_reg  <= head.done;
        end
        if (rd_adv) begin
            out_item_reg.texel         <= rd_black_reg ? '0 : pack_texel(rd_rgb_reg);
            out_item_reg.texel_address <= rd_addr_reg;
            out_item_reg.image_done    <= rd_done_reg;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_pixel) |-> (!rd_valid_reg || rd_adv))
        else $error("read stage overwritten while holding a pixel");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg)
        else $error("output item dropped during stall");

    a_fill_out: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_adv |=> out_valid_reg)
        else $error("read stage advanced without filling output");

endmodule

### hdl/indexed_to_swizzled_rgb5a1_texels_unit.sv
// Top level of the indexed-to-swizzled RGB5A1 texel unit.
`timescale 1ns / 1ps
//
// Usage: write the palette first (items with operation = palette write, no
// result), then stream pixel codes in raster order (one result per pixel).
// s_* channel: valid/ready input items. m_* channel: valid/ready result items
// carrying the RGB5A1 texel, its byte address in the 16-byte x 8-row swizzled
// texture, and image_done on the last pixel of the image.
// cfg_*: plain write port; index 0 = image_width, 1 = image_height. A write
// restarts the image at column 0, row 0. Write only while the unit is idle.
// Throughput: one item per clock while the queue is not full; one queue entry
// leaves per clock unless m_ready holds the output, so the palette RAM sees
// either its write or its read in a given cycle. An accepted pixel passes the
// queue entry, the palette read register and the output register, in that
// order, before it shows on m_valid.
// Back-pressure: m_ready low holds the output register; the read stage and a
// four-entry queue keep absorbing items, and s_ready drops once the queue
// fills. Reset clears counters, queue and valid flags; dimensions return to
// 320 x 240. The palette is not cleared: read only entries already written.
//

module indexed_to_swizzled_rgb5a1_texels_unit #(
    parameter int MAX_DIM_LOG2    = 9,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [itsr_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  itsr_pkg::in_item_t            s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output itsr_pkg::out_item_t           m_item
);

    logic                     push;
    logic                     pop;
    itsr_pkg::work_t          push_entry;
    itsr_pkg::work_t          head;
    itsr_pkg::queue_status_t  q_status;

    // Front: counters and address, one item per clock into a non-full queue
    itsr_front #(
        .MAX_DIM_LOG2 (MAX_DIM_LOG2)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue decouples intake from palette access and output stalls
    itsr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Back: palette RAM, pack, output register
    itsr_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
